>>> hw/rtl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants of the rgb to hsv converter
// Channel and hue widths, divider sizing, pipeline depth and stage payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package rth_pkg;

  // field widths
  localparam int COLOR_BITS    = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_BITS      = 9 + HUE_FRAC_BITS;

  // full-scale channel value, used as the saturation scale
  localparam int CHAN_MAX = (1 << COLOR_BITS) - 1;

  // hue angles in fixed point
  localparam int HUE_SCALE = 60 << HUE_FRAC_BITS;
  localparam int HUE_120   = 120 << HUE_FRAC_BITS;
  localparam int HUE_240   = 240 << HUE_FRAC_BITS;
  localparam int HUE_360   = 360 << HUE_FRAC_BITS;

  // divider sizing: numerator holds mag * HUE_SCALE or CHAN_MAX * delta,
  // the quotient never exceeds HUE_SCALE (or CHAN_MAX for saturation)
  localparam int HUE_Q_BITS   = $clog2(HUE_SCALE + 1);
  localparam int DIV_Q_BITS   = (HUE_Q_BITS > COLOR_BITS) ? HUE_Q_BITS : COLOR_BITS;
  localparam int DIV_NUM_BITS = COLOR_BITS + DIV_Q_BITS;

  // front register, one stage per quotient bit, output register
  localparam int NSTAGE = DIV_Q_BITS + 2;

  // channel that holds the maximum, in hue priority order
  typedef enum logic [1:0] {
    BR_RED   = 2'd0,
    BR_GREEN = 2'd1,
    BR_BLUE  = 2'd2
  } branch_e;

  // data that rides alongside the dividers
  typedef struct packed {
    logic [COLOR_BITS-1:0] mx;
    logic                  neg;
    branch_e               branch;
    logic                  grey;
  } side_t;

  // result of the front end for one item
  typedef struct packed {
    logic [DIV_NUM_BITS-1:0] num_h;
    logic [DIV_NUM_BITS-1:0] num_s;
    logic [COLOR_BITS-1:0]   delta;
    side_t                   side;
  } front_t;

  // per-stage load enables and valid bits
  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] valid;
  } pipe_t;

endpackage

`default_nettype wire

>>> hw/rtl/rgb_to_hsv.sv
// Front register, 12-stage dividers (one quotient bit a stage), output register.
// Throughput: one item per clock while the output is not stalled.
// Stalls back up stage by stage; empty stages still take new items.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv: pixel color conversion from rgb to hsv
// Front end, two pipelined dividers for hue and saturation, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rth_pkg::COLOR_BITS-1:0]  red_i,
  input  logic [rth_pkg::COLOR_BITS-1:0]  green_i,
  input  logic [rth_pkg::COLOR_BITS-1:0]  blue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rth_pkg::HUE_BITS-1:0]    hue_o,
  output logic [rth_pkg::COLOR_BITS-1:0]  saturation_o,
  output logic [rth_pkg::COLOR_BITS-1:0]  brightness_o
);

  rth_pkg::pipe_t  pipe;
  rth_pkg::front_t front;

  logic [rth_pkg::DIV_NUM_BITS-1:0] num_h_q;
  logic [rth_pkg::DIV_NUM_BITS-1:0] num_s_q;
  logic [rth_pkg::COLOR_BITS-1:0]   delta_q;
  rth_pkg::side_t                   side_q [rth_pkg::DIV_Q_BITS+1];

  logic [rth_pkg::DIV_Q_BITS-1:0]   quo_h;
  logic [rth_pkg::DIV_Q_BITS-1:0]   quo_s;

  logic [rth_pkg::HUE_BITS:0]       hue_base;
  logic [rth_pkg::HUE_BITS:0]       hue_sum;
  logic [rth_pkg::HUE_BITS-1:0]     hue_d;
  logic [rth_pkg::COLOR_BITS-1:0]   sat_d;
  logic [rth_pkg::HUE_BITS-1:0]     hue_q;
  logic [rth_pkg::COLOR_BITS-1:0]   sat_q;
  logic [rth_pkg::COLOR_BITS-1:0]   bri_q;

  // stall control
  rth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .pipe_o      (pipe)
  );

  // max/min and operands
  rth_front u_front (
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .front_o (front)
  );

  // front register
  always_ff @(posedge clk_i) begin
    if (pipe.en[0]) begin
      num_h_q   <= front.num_h;
      num_s_q   <= front.num_s;
      delta_q   <= front.delta;
      side_q[0] <= front.side;
    end
  end

  // side data alongside the divider stages
  for (genvar k = 1; k <= rth_pkg::DIV_Q_BITS; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (pipe.en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // hue quotient: mag * 60 deg / delta
  rth_div u_div_hue (
    .clk_i (clk_i),
    .en_i  (pipe.en[rth_pkg::DIV_Q_BITS:1]),
    .num_i (num_h_q),
    .den_i (delta_q),
    .quo_o (quo_h)
  );

  // saturation quotient: full scale * delta / max
  rth_div u_div_sat (
    .clk_i (clk_i),
    .en_i  (pipe.en[rth_pkg::DIV_Q_BITS:1]),
    .num_i (num_s_q),
    .den_i (side_q[0].mx),
    .quo_o (quo_s)
  );

  // hue offset by branch, sign, wrap, grey override
  always_comb begin
    unique case (side_q[rth_pkg::DIV_Q_BITS].branch)
      rth_pkg::BR_RED: begin
        hue_base = side_q[rth_pkg::DIV_Q_BITS].neg
                 ? (rth_pkg::HUE_BITS+1)'(rth_pkg::HUE_360) : '0;
      end
      rth_pkg::BR_GREEN: hue_base = (rth_pkg::HUE_BITS+1)'(rth_pkg::HUE_120);
      rth_pkg::BR_BLUE:  hue_base = (rth_pkg::HUE_BITS+1)'(rth_pkg::HUE_240);
      default:           hue_base = '0;
    endcase
    if (side_q[rth_pkg::DIV_Q_BITS].neg) begin
      hue_sum = hue_base - (rth_pkg::HUE_BITS+1)'(quo_h);
    end else begin
      hue_sum = hue_base + (rth_pkg::HUE_BITS+1)'(quo_h);
    end
    if (hue_sum >= (rth_pkg::HUE_BITS+1)'(rth_pkg::HUE_360)) begin
      hue_sum = hue_sum - (rth_pkg::HUE_BITS+1)'(rth_pkg::HUE_360);
    end
    hue_d = hue_sum[rth_pkg::HUE_BITS-1:0];
    sat_d = quo_s[rth_pkg::COLOR_BITS-1:0];
    if (side_q[rth_pkg::DIV_Q_BITS].grey) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (pipe.en[rth_pkg::NSTAGE-1]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= side_q[rth_pkg::DIV_Q_BITS].mx;
    end
  end

  assign out_valid_o  = pipe.valid[rth_pkg::NSTAGE-1];
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bri_q;

  // an empty output stage means every stage can load
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_o |-> in_ready_o
  ) else $error("input stalled while output stage empty");

  // hue stays below 360 degrees
  a_hue_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_o < rth_pkg::HUE_BITS'(rth_pkg::HUE_360))
  ) else $error("hue out of range");

  // zero saturation only for grey pixels, which carry zero hue
  a_grey_hue: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (saturation_o == '0)) |-> (hue_o == '0)
  ) else $error("grey item with nonzero hue");

  // nonzero saturation needs a nonzero maximum
  a_sat_bri: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (saturation_o != '0)) |-> (brightness_o != '0)
  ) else $error("saturation without brightness");

endmodule

`default_nettype wire

>>> hw/rtl/rth_front.sv
// ----------------------------------------------------------------------------
// rth_front: max/min search and divider operand setup
// Picks max and min, the hue branch and sign, and builds both numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_front (
  input  logic [rth_pkg::COLOR_BITS-1:0] red_i,
  input  logic [rth_pkg::COLOR_BITS-1:0] green_i,
  input  logic [rth_pkg::COLOR_BITS-1:0] blue_i,
  output rth_pkg::front_t                front_o
);

  logic [rth_pkg::COLOR_BITS-1:0] mx;
  logic [rth_pkg::COLOR_BITS-1:0] mn;
  logic [rth_pkg::COLOR_BITS-1:0] rg_max;
  logic [rth_pkg::COLOR_BITS-1:0] rg_min;
  logic [rth_pkg::COLOR_BITS-1:0] delta;
  logic [rth_pkg::COLOR_BITS-1:0] mag;
  logic                           neg;
  rth_pkg::branch_e               branch;

  // max and min of the three channels
  always_comb begin
    rg_max = (red_i > green_i) ? red_i : green_i;
    rg_min = (red_i > green_i) ? green_i : red_i;
    mx     = (rg_max > blue_i) ? rg_max : blue_i;
    mn     = (rg_min > blue_i) ? blue_i : rg_min;
    delta  = mx - mn;
  end

  // hue branch, red first on ties, then green
  always_comb begin
    if (red_i == mx) begin
      branch = rth_pkg::BR_RED;
      neg    = green_i < blue_i;
      mag    = neg ? (blue_i - green_i) : (green_i - blue_i);
    end else if (green_i == mx) begin
      branch = rth_pkg::BR_GREEN;
      neg    = blue_i < red_i;
      mag    = neg ? (red_i - blue_i) : (blue_i - red_i);
    end else begin
      branch = rth_pkg::BR_BLUE;
      neg    = red_i < green_i;
      mag    = neg ? (green_i - red_i) : (red_i - green_i);
    end
  end

  // numerators by constant multiply
  always_comb begin
    front_o.num_h = rth_pkg::DIV_NUM_BITS'(mag)
                  * rth_pkg::DIV_NUM_BITS'(rth_pkg::HUE_SCALE);
    front_o.num_s = rth_pkg::DIV_NUM_BITS'(delta)
                  * rth_pkg::DIV_NUM_BITS'(rth_pkg::CHAN_MAX);
    front_o.delta       = delta;
    front_o.side.mx     = mx;
    front_o.side.neg    = neg;
    front_o.side.branch = branch;
    front_o.side.grey   = (delta == '0);
  end

endmodule

`default_nettype wire

>>> hw/rtl/rth_div.sv
// ----------------------------------------------------------------------------
// rth_div: pipelined restoring divider
// One quotient bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_div (
  input  logic                              clk_i,
  input  logic [rth_pkg::DIV_Q_BITS-1:0]    en_i,
  input  logic [rth_pkg::DIV_NUM_BITS-1:0]  num_i,
  input  logic [rth_pkg::COLOR_BITS-1:0]    den_i,
  output logic [rth_pkg::DIV_Q_BITS-1:0]    quo_o
);

  logic [rth_pkg::DIV_NUM_BITS-1:0] rem_q [rth_pkg::DIV_Q_BITS];
  logic [rth_pkg::COLOR_BITS-1:0]   den_q [rth_pkg::DIV_Q_BITS];
  logic [rth_pkg::DIV_Q_BITS-1:0]   quo_q [rth_pkg::DIV_Q_BITS];

  for (genvar k = 0; k < rth_pkg::DIV_Q_BITS; k++) begin : g_stage
    localparam int BIT = rth_pkg::DIV_Q_BITS - 1 - k;

    logic [rth_pkg::DIV_NUM_BITS-1:0] rem_in;
    logic [rth_pkg::COLOR_BITS-1:0]   den_in;
    logic [rth_pkg::DIV_Q_BITS-1:0]   quo_in;
    logic [rth_pkg::DIV_NUM_BITS-1:0] trial;
    logic [rth_pkg::DIV_NUM_BITS-1:0] rem_d;
    logic [rth_pkg::DIV_Q_BITS-1:0]   quo_d;

    // operands from the previous stage or the ports
    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // compare and subtract the shifted divisor
    always_comb begin
      trial = rth_pkg::DIV_NUM_BITS'(den_in) << BIT;
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= trial) begin
        rem_d      = rem_in - trial;
        quo_d[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[rth_pkg::DIV_Q_BITS-1];

endmodule

`default_nettype wire

>>> hw/rtl/rth_ctrl.sv
// ----------------------------------------------------------------------------
// rth_ctrl: pipeline valid bits and stall control
// A stage loads when it is empty or its item moves on; bubbles collapse.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output rth_pkg::pipe_t pipe_o
);

  logic [rth_pkg::NSTAGE-1:0] valid_q;
  logic [rth_pkg::NSTAGE-1:0] valid_d;
  logic [rth_pkg::NSTAGE-1:0] en;

  // load enables, from the output back to the input
  always_comb begin
    en[rth_pkg::NSTAGE-1] = !valid_q[rth_pkg::NSTAGE-1] || out_ready_i;
    for (int k = rth_pkg::NSTAGE - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < rth_pkg::NSTAGE; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = en[0];
  assign pipe_o.en    = en;
  assign pipe_o.valid = valid_q;

endmodule

`default_nettype wire

>>> verif/tb_rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv: self-checking bench for the rgb to hsv converter
// Sends directed and random pixels with random gaps and output stalls,
// predicts hue, saturation and value per pixel and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

typedef logic [rth_pkg::COLOR_BITS-1:0] chan_t;

// expected or observed hsv triple
typedef struct packed {
  logic [rth_pkg::HUE_BITS-1:0] hue;
  chan_t                        sat;
  chan_t                        val;
} hsv_t;

// pixel sent in, with the hsv it should produce
typedef struct {
  chan_t r;
  chan_t g;
  chan_t b;
  hsv_t  want;
} pixel_job_t;

class hsv_scoreboard;
  localparam int HUE_UNIT  = 1 << rth_pkg::HUE_FRAC_BITS;
  localparam int FULL_TURN = 360 * HUE_UNIT;
  localparam int CHAN_FULL = (1 << rth_pkg::COLOR_BITS) - 1;

  pixel_job_t pending_hsv[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  // hue, saturation and value of one pixel
  function hsv_t hsv_of(int r, int g, int b);
    int   mx, mn, span, diff, mag, quot, base, h;
    hsv_t res;
    mx = (r > g) ? r : g;
    mx = (b > mx) ? b : mx;
    mn = (r < g) ? r : g;
    mn = (b < mn) ? b : mn;
    span = mx - mn;
    res = '0;
    res.val = chan_t'(mx);
    if (span != 0) begin
      // hue sector by max channel, red wins ties, then green
      if (r == mx) begin
        diff = g - b;
        base = 0;
      end else if (g == mx) begin
        diff = b - r;
        base = 120 * HUE_UNIT;
      end else begin
        diff = r - g;
        base = 240 * HUE_UNIT;
      end
      // quotient truncated toward zero
      mag  = (diff < 0) ? -diff : diff;
      quot = (mag * 60 * HUE_UNIT) / span;
      if (diff < 0) quot = -quot;
      h = quot + base;
      if (h < 0) h += FULL_TURN;
      if (h >= FULL_TURN) h -= FULL_TURN;
      res.hue = h[rth_pkg::HUE_BITS-1:0];
      res.sat = chan_t'((CHAN_FULL * span) / mx);
    end
    return res;
  endfunction

  function void note_pixel(chan_t r, chan_t g, chan_t b);
    pixel_job_t job;
    job.r    = r;
    job.g    = g;
    job.b    = b;
    job.want = hsv_of(r, g, b);
    pending_hsv.push_back(job);
  endfunction

  function void check_result(hsv_t got);
    pixel_job_t job;
    if (pending_hsv.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("error: result with no pixel pending: hue=%0d sat=%0d val=%0d",
                 got.hue, got.sat, got.val);
      return;
    end
    job = pending_hsv.pop_front();
    if (got.hue !== job.want.hue || got.sat !== job.want.sat ||
        got.val !== job.want.val) begin
      errors++;
      if (errors <= 10)
        $display("error: rgb=(%0d,%0d,%0d) exp h/s/v=%0d/%0d/%0d got %0d/%0d/%0d",
                 job.r, job.g, job.b, job.want.hue, job.want.sat, job.want.val,
                 got.hue, got.sat, got.val);
    end
  endfunction
endclass

module tb_rgb_to_hsv;
  localparam int PIXEL_COUNT = 850;
  localparam int HOLD_CYCLES = 80;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  chan_t                        red_i = '0;
  chan_t                        green_i = '0;
  chan_t                        blue_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [rth_pkg::HUE_BITS-1:0] hue_o;
  chan_t                        saturation_o;
  chan_t                        brightness_o;

  // request for one long output hold-off
  bit            hold_sink = 1'b0;
  hsv_scoreboard sb = new();

  rgb_to_hsv u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  always #5 clk_i = ~clk_i;

  // gap length, mostly short with a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // channel value biased toward the ends of the range
  function automatic chan_t edge_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return chan_t'(1);
      2: return '1;
      3: return '1 - chan_t'(1);
      default: return chan_t'($urandom);
    endcase
  endfunction

  // offer one pixel, hold it until taken; called and returns at a falling edge
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // drop valid and put junk on the channels while idling
  task automatic idle_in(input int n);
    in_valid_i <= 1'b0;
    red_i      <= chan_t'($urandom);
    green_i    <= chan_t'($urandom);
    blue_i     <= chan_t'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  // both handshakes seen before any register update of this edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_pixel(red_i, green_i, blue_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{hue: hue_o, sat: saturation_o, val: brightness_o});
  end

  // output side: phases of varying stall rate, plus one long hold-off on request
  initial begin : sink
    int stall_left;
    int stall_pct;
    int seg_left;
    stall_left = 0;
    stall_pct  = 0;
    seg_left   = 0;
    forever begin
      @(negedge clk_i);
      if (seg_left == 0) begin
        seg_left = 150;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      seg_left--;
      if (hold_sink) begin
        hold_sink  = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin : stim
    int    gap_pct;
    int    m;
    chan_t r, g, b, lo;
    gap_pct = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: black, white, grey, primaries, ties, wrap, tiny spans
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    idle_in(3);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1, 8'd1, 8'd0);
    idle_in(1);
    send_pixel(8'd200, 8'd100, 8'd150);
    send_pixel(8'd100, 8'd200, 8'd150);
    send_pixel(8'd100, 8'd150, 8'd200);
    send_pixel(8'd150, 8'd200, 8'd100);
    send_pixel(8'd200, 8'd150, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd1, 8'd255, 8'd254);

    // random pixels in segments of differing input gap rate
    for (int i = 0; i < PIXEL_COUNT; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 5;
          2: gap_pct = 25;
          default: gap_pct = 50;
        endcase
      end
      if (i == 400) hold_sink = 1'b1;
      case ($urandom_range(0, 4))
        0, 1: begin
          r = chan_t'($urandom);
          g = chan_t'($urandom);
          b = chan_t'($urandom);
        end
        2: begin
          // grey or a tie for the maximum
          m  = $urandom_range(1, 255);
          lo = chan_t'($urandom_range(0, m));
          case ($urandom_range(0, 3))
            0: begin r = chan_t'(m); g = chan_t'(m); b = chan_t'(m); end
            1: begin r = chan_t'(m); g = chan_t'(m); b = lo; end
            2: begin r = chan_t'(m); g = lo; b = chan_t'(m); end
            default: begin r = lo; g = chan_t'(m); b = chan_t'(m); end
          endcase
        end
        3: begin
          r = edge_value();
          g = edge_value();
          b = edge_value();
        end
        default: begin
          // span of a few codes only
          m = $urandom_range(2, 255);
          r = chan_t'(m - $urandom_range(0, 2));
          g = chan_t'(m - $urandom_range(0, 2));
          b = chan_t'(m - $urandom_range(0, 2));
        end
      endcase
      send_pixel(r, g, b);
      // keep offering back to back through the long output hold-off
      if (!(i >= 400 && i < 460) && $urandom_range(0, 99) < gap_pct) idle_in(pick_gap());
    end
    in_valid_i <= 1'b0;

    // drain, then allow for stray results
    while (sb.pending_hsv.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_hsv.size() == 0) begin
      $display("** rgb_to_hsv: PASSED **");
    end else begin
      $display("** rgb_to_hsv: FAILED **");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #8000000;
    $display("** rgb_to_hsv: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
